// ----- rtl/core/tdc_pkg.sv -----
`timescale 1ns / 1ps

package tdc_pkg;

	// raw samples per poll and derived widths
	localparam int unsigned SamplesPerPoll = 5;
	localparam int unsigned VoteW          = $clog2(SamplesPerPoll + 1);

	// configuration register indexes
	localparam logic [7:0] RegVoteThreshold    = 8'd0;
	localparam logic [7:0] RegDebounceInterval = 8'd1;
	localparam logic [7:0] RegRequiredCount    = 8'd2;
	localparam logic [7:0] RegCooldownTime     = 8'd3;

	// configuration reset values
	localparam logic [2:0]  VoteThresholdRst    = 3'd3;
	localparam logic [15:0] DebounceIntervalRst = 16'd10;
	localparam logic [7:0]  RequiredCountRst    = 8'd8;
	localparam logic [15:0] CooldownTimeRst     = 16'd1000;

	localparam logic [7:0] CountMax = 8'd255;

	typedef enum logic [1:0] {
		PH_IDLE      = 2'd0,
		PH_DEBOUNCE  = 2'd1,
		PH_TRIGGERED = 2'd2,
		PH_COOLDOWN  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [31:0]               now_ms;
		logic [SamplesPerPoll-1:0] pin_samples;
	} tdc_in_t;

	typedef struct packed {
		logic       fire;
		logic [1:0] phase;
		logic [7:0] press_count;
		logic       stable_level;
	} tdc_out_t;

endpackage

// ----- rtl/core/trigger_debounce_cooldown_fsm.sv -----
`timescale 1ns / 1ps
// Two register stages (input register, result register); a poll moves into the result
// register when it is empty or being drained. Throughput: one poll per cycle unless the
// output stalls; the phase, start time and count update in a single pass of popcount,
// 32-bit elapsed-time subtract and compare between the two registers.
// Reset (arst_n low, asynchronous): phase idle, start time and count zero, configuration
// registers at 3 / 10 / 8 / 1000, both pipeline stages empty.
module trigger_debounce_cooldown_fsm (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  tdc_pkg::tdc_in_t        in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output tdc_pkg::tdc_out_t       out_data,
	input  logic                    cfg_we,
	input  logic [7:0]              cfg_index,
	input  logic [15:0]             cfg_wdata
);
	import tdc_pkg::*;

	logic [2:0]  vote_threshold_q;
	logic [15:0] debounce_interval_q;
	logic [7:0]  required_count_q;
	logic [15:0] cooldown_time_q;

	logic        valid_s1;
	tdc_in_t     data_s1;
	logic        advance;

	phase_t      phase_q, phase_d;
	logic [31:0] phase_start_q, phase_start_d;
	logic [7:0]  stable_count_q, stable_count_d;

	logic [VoteW-1:0] vote_cnt;
	logic             stable;
	logic [31:0]      elapsed;
	logic [7:0]       count_inc;
	logic             fire_d;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vote_threshold_q    <= VoteThresholdRst;
			debounce_interval_q <= DebounceIntervalRst;
			required_count_q    <= RequiredCountRst;
			cooldown_time_q     <= CooldownTimeRst;
		end else if (cfg_we) begin
			case (cfg_index)
				RegVoteThreshold:    vote_threshold_q    <= cfg_wdata[2:0];
				RegDebounceInterval: debounce_interval_q <= cfg_wdata;
				RegRequiredCount:    required_count_q    <= cfg_wdata[7:0];
				RegCooldownTime:     cooldown_time_q     <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// stage 1 moves on when the result register is empty or being drained
	assign advance  = !out_valid || out_ready;
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	// threshold vote over the raw samples
	always_comb begin
		vote_cnt = '0;
		for (int i = 0; i < SamplesPerPoll; i++) begin
			vote_cnt = vote_cnt + VoteW'(data_s1.pin_samples[i]);
		end
	end

	assign stable    = ({{(8 - VoteW){1'b0}}, vote_cnt} >= {5'd0, vote_threshold_q});
	assign elapsed   = data_s1.now_ms - phase_start_q;
	assign count_inc = (stable_count_q < CountMax) ? stable_count_q + 8'd1 : stable_count_q;

	// next phase, start time and count for the poll in stage 1
	always_comb begin
		phase_d        = phase_q;
		phase_start_d  = phase_start_q;
		stable_count_d = stable_count_q;
		fire_d         = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (stable) begin
					phase_d        = PH_DEBOUNCE;
					phase_start_d  = data_s1.now_ms;
					stable_count_d = 8'd1;
				end
			end
			PH_DEBOUNCE: begin
				if (elapsed >= {16'd0, debounce_interval_q}) begin
					if (stable) begin
						stable_count_d = count_inc;
						phase_start_d  = data_s1.now_ms;
						if (count_inc >= required_count_q) begin
							phase_d = PH_TRIGGERED;
							fire_d  = 1'b1;
						end
					end else begin
						phase_d        = PH_IDLE;
						stable_count_d = 8'd0;
					end
				end
			end
			PH_TRIGGERED: begin
				if (!stable) begin
					phase_d       = PH_COOLDOWN;
					phase_start_d = data_s1.now_ms;
				end
			end
			PH_COOLDOWN: begin
				if (elapsed >= {16'd0, cooldown_time_q}) begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// state register, updated once per poll leaving stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			phase_start_q  <= '0;
			stable_count_q <= '0;
		end else if (valid_s1 && advance) begin
			phase_q        <= phase_d;
			phase_start_q  <= phase_start_d;
			stable_count_q <= stable_count_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_data.fire         <= fire_d;
			out_data.phase        <= 2'(phase_d);
			out_data.press_count  <= stable_count_d;
			out_data.stable_level <= stable;
		end
	end

endmodule

// ----- rtl/core/tdc_checker.sv -----
`timescale 1ns / 1ps
module tdc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input tdc_pkg::tdc_out_t out_data
);
	import tdc_pkg::*;

	// a stalled result transfer holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// fire only on entry to the triggered phase
	a_fire_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.fire |-> out_data.phase == 2'(PH_TRIGGERED))
		else $error("fire outside triggered phase");

	// a trigger needs at least one counted stable poll
	a_fire_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.fire |-> out_data.press_count != 8'd0)
		else $error("fire with zero count");

	// an unstable poll never leaves the machine triggered
	a_trig_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.phase == 2'(PH_TRIGGERED) |-> out_data.stable_level)
		else $error("triggered on an unstable poll");

endmodule

bind trigger_debounce_cooldown_fsm tdc_checker u_tdc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	import tdc_pkg::*;

	localparam int unsigned WatchdogLimit = 2000;
	localparam int unsigned HoldOffCycles = 120;
	localparam int unsigned SettleCycles  = 8;

	// register indexes past the last one, which the block must ignore
	localparam logic [7:0] RegBeyondLast = 8'd4;
	localparam logic [7:0] RegIndexTop   = 8'hFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic     in_valid = 1'b0;
	logic     in_ready;
	tdc_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	tdc_out_t out_data;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;

	// shadow of the configuration registers
	logic [2:0]  vote_thr    = VoteThresholdRst;
	logic [15:0] db_interval = DebounceIntervalRst;
	logic [7:0]  fire_count  = RequiredCountRst;
	logic [15:0] cool_time   = CooldownTimeRst;

	// shadow of the debounce state
	phase_t      fsm_phase = PH_IDLE;
	logic [31:0] phase_t0  = '0;
	logic [7:0]  press_cnt = '0;

	tdc_out_t    expected_polls[$];
	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned quiet_cycles = 0;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;
	bit          sender_idle = 1'b1;
	bit          receiver_idle = 1'b1;
	logic [31:0] clock_ms = 32'd5000;

	trigger_debounce_cooldown_fsm u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// advance the shadow debouncer by one poll and return the result it owes
	function automatic tdc_out_t debounce_predict(tdc_in_t poll);
		int unsigned active;
		logic        hit;
		logic [31:0] elapsed;
		tdc_out_t    res;
		active = 0;
		for (int i = 0; i < SamplesPerPoll; i++) begin
			if (poll.pin_samples[i]) active++;
		end
		hit = (active >= vote_thr);
		elapsed = poll.now_ms - phase_t0;
		res.fire = 1'b0;
		case (fsm_phase)
			PH_IDLE: begin
				if (hit) begin
					fsm_phase = PH_DEBOUNCE;
					phase_t0 = poll.now_ms;
					press_cnt = 8'd1;
				end
			end
			PH_DEBOUNCE: begin
				if (elapsed >= {16'd0, db_interval}) begin
					if (hit) begin
						if (press_cnt < CountMax) press_cnt++;
						phase_t0 = poll.now_ms;
						if (press_cnt >= fire_count) begin
							fsm_phase = PH_TRIGGERED;
							res.fire = 1'b1;
						end
					end else begin
						fsm_phase = PH_IDLE;
						press_cnt = '0;
					end
				end
			end
			PH_TRIGGERED: begin
				if (!hit) begin
					fsm_phase = PH_COOLDOWN;
					phase_t0 = poll.now_ms;
				end
			end
			default: begin
				if (elapsed >= {16'd0, cool_time}) fsm_phase = PH_IDLE;
			end
		endcase
		res.phase = fsm_phase;
		res.press_count = press_cnt;
		res.stable_level = hit;
		return res;
	endfunction

	// pin pattern that votes active or inactive under the current threshold
	function automatic logic [SamplesPerPoll-1:0] pins_for(bit want_active);
		logic [SamplesPerPoll-1:0] p;
		int unsigned k;
		if (want_active && vote_thr <= SamplesPerPoll) begin
			p = '1;
			k = $urandom_range(0, SamplesPerPoll - vote_thr);
			repeat (k) p[$urandom_range(0, SamplesPerPoll - 1)] = 1'b0;
		end else if (!want_active && vote_thr > 0) begin
			p = '0;
			k = (vote_thr > SamplesPerPoll) ? SamplesPerPoll : vote_thr - 1;
			k = $urandom_range(0, k);
			repeat (k) p[$urandom_range(0, SamplesPerPoll - 1)] = 1'b1;
		end else begin
			p = SamplesPerPoll'($urandom);
		end
		return p;
	endfunction

	// mostly land just past the span, sometimes inside it, rarely anywhere
	function automatic logic [31:0] time_step(int unsigned span);
		case ($urandom_range(0, 19))
			0:          return $urandom();
			1, 2, 3, 4: return $urandom_range(0, span);
			default:    return span + $urandom_range(0, 2);
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR: %s", msg);
		mismatches++;
	endtask

	// predict on input transfers, compare on output transfers
	always @(posedge clk) begin
		tdc_out_t want;
		if (out_valid && out_ready) begin
			if (expected_polls.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no poll outstanding",
					results_seen));
			end else begin
				want = expected_polls.pop_front();
				if (out_data.fire !== want.fire)
					report_mismatch($sformatf("result %0d fire got %b want %b",
						results_seen, out_data.fire, want.fire));
				if (out_data.phase !== want.phase)
					report_mismatch($sformatf("result %0d phase got %0d want %0d",
						results_seen, out_data.phase, want.phase));
				if (out_data.press_count !== want.press_count)
					report_mismatch($sformatf("result %0d press_count got %0d want %0d",
						results_seen, out_data.press_count, want.press_count));
				if (out_data.stable_level !== want.stable_level)
					report_mismatch($sformatf("result %0d stable_level got %b want %b",
						results_seen, out_data.stable_level, want.stable_level));
			end
			results_seen++;
		end
		if (in_valid && in_ready) expected_polls.push_back(debounce_predict(in_data));
	end

	// receiver: long hold-off on request, otherwise random stall bursts
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (receiver_idle && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 15);
		end
	end

	// give up when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WatchdogLimit) begin
				$display("ERROR: no transfer for %0d cycles", quiet_cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// offer one poll and hold it until the transfer
	task automatic send_poll(input logic [31:0] t, input logic [SamplesPerPoll-1:0] pins);
		@(negedge clk);
		if (sender_idle && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_data <= '{now_ms: t, pin_samples: pins};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// drop valid and wait until every outstanding result is back
	task automatic wait_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_polls.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [7:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			RegVoteThreshold:    vote_thr = data[2:0];
			RegDebounceInterval: db_interval = data;
			RegRequiredCount:    fire_count = data[7:0];
			RegCooldownTime:     cool_time = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// write all four registers; junk in the unused upper bits must be dropped
	task automatic write_settings(input logic [2:0] thr, input logic [15:0] interval,
			input logic [7:0] req, input logic [15:0] cool);
		wait_results();
		cfg_write(RegVoteThreshold, {13'($urandom), thr});
		cfg_write(RegDebounceInterval, interval);
		cfg_write(RegRequiredCount, {8'($urandom), req});
		cfg_write(RegCooldownTime, cool);
	endtask

	// full press with the reset settings, timestamps crossing the wrap
	task automatic check_reset_settings();
		send_poll(32'd0, 5'b00000);
		send_poll(32'hFFFF_FFFF, 5'b00011);
		send_poll(32'hFFFF_FFFA, 5'b00111);
		send_poll(32'hFFFF_FFFF, 5'b11111);
		for (int k = 1; k <= 7; k++)
			send_poll(32'hFFFF_FFFA + 32'(10 * k), k[0] ? 5'b11100 : 5'b10101);
		send_poll(32'h0000_0040, 5'b11111);
		send_poll(32'h0000_0041, 5'b01000);
		send_poll(32'h0000_0041 + 32'd999, 5'b00000);
		send_poll(32'h0000_0041 + 32'd1000, 5'b00000);
		// noise after the interval drops back to idle
		send_poll(32'd2000, 5'b11111);
		send_poll(32'd2005, 5'b11111);
		send_poll(32'd2010, 5'b00001);
	endtask

	// register extremes, unused indexes and masking
	task automatic check_setting_corners();
		write_settings(3'd5, 16'hFFFF, 8'd1, 16'hFFFF);
		send_poll(32'h1000_0000, 5'b11111);
		send_poll(32'h1000_0000 + 32'd65534, 5'b11111);
		send_poll(32'h1000_0000 + 32'd65535, 5'b11111);
		send_poll(32'h1001_0000, 5'b11110);
		send_poll(32'h1001_0000 + 32'd65534, 5'b00000);
		send_poll(32'h1001_0000 + 32'd65535, 5'b00000);
		// threshold zero makes every poll stable; required count zero fires on the first debounce poll
		write_settings(3'd0, 16'd0, 8'd0, 16'd0);
		send_poll(32'h2000_0000, 5'b00000);
		send_poll(32'h2000_0000, 5'b00000);
		// threshold above the sample count makes every poll unstable
		wait_results();
		cfg_write(RegVoteThreshold, 16'd7);
		send_poll(32'h2000_0001, 5'b11111);
		send_poll(32'h2000_0001, 5'b11111);
		wait_results();
		cfg_write(RegBeyondLast, 16'hFFFF);
		cfg_write(RegIndexTop, 16'h0000);
		cfg_write(RegVoteThreshold, 16'hFFF9);
		send_poll(32'h2000_0002, 5'b00001);
	endtask

	// stall the receiver long enough for the block to refuse input
	task automatic check_full_pipeline();
		wait_results();
		sender_idle = 1'b0;
		hold_left = HoldOffCycles;
		for (int n = 0; n < 30; n++) begin
			clock_ms += $urandom_range(0, 20);
			send_poll(clock_ms, pins_for($urandom_range(0, 1)));
		end
		wait_results();
		sender_idle = 1'b1;
	endtask

	// press and release sequences with noise under a random setting
	task automatic run_random_presses(input int unsigned n_items, input bit long_run);
		logic [2:0]  thr;
		logic [15:0] interval;
		logic [7:0]  req;
		logic [15:0] cool;
		int unsigned sent;
		int unsigned len;
		bit          noise;
		if (long_run) begin
			thr = 3'($urandom_range(1, 5));
			interval = 16'($urandom_range(0, 3));
			req = CountMax;
			cool = 16'($urandom_range(0, 50));
		end else begin
			thr = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
				: 3'($urandom_range(1, 5));
			case ($urandom_range(0, 7))
				0:       interval = 16'd0;
				1:       interval = 16'hFFFF;
				default: interval = 16'($urandom_range(1, 30));
			endcase
			req = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 8));
			case ($urandom_range(0, 7))
				0:       cool = 16'd0;
				1:       cool = 16'hFFFF;
				default: cool = 16'($urandom_range(1, 100));
			endcase
		end
		write_settings(thr, interval, req, cool);
		sent = 0;
		while (sent < n_items) begin
			// press
			len = $urandom_range(0, 1) ? fire_count + $urandom_range(0, 5)
				: $urandom_range(1, fire_count + 3);
			for (int i = 0; i < len && sent < n_items; i++) begin
				noise = !long_run && $urandom_range(0, 11) == 0;
				clock_ms += time_step(db_interval);
				send_poll(clock_ms, pins_for(!noise));
				sent++;
			end
			// release
			len = $urandom_range(1, 6);
			for (int i = 0; i < len && sent < n_items; i++) begin
				noise = $urandom_range(0, 11) == 0;
				clock_ms += time_step(cool_time >> $urandom_range(0, 2));
				send_poll(clock_ms, pins_for(noise));
				sent++;
			end
		end
	endtask

	// back-to-back traffic with neither side idling
	task automatic check_steady_flow();
		wait_results();
		sender_idle = 1'b0;
		receiver_idle = 1'b0;
		run_random_presses(60, 1'b0);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		check_reset_settings();
		check_setting_corners();
		check_full_pipeline();
		for (int p = 0; p < 6; p++) run_random_presses(110, 1'b0);
		run_random_presses(300, 1'b1);
		check_steady_flow();
		wait_results();
		repeat (SettleCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/tdc_pkg.sv
rtl/core/trigger_debounce_cooldown_fsm.sv
rtl/core/tdc_checker.sv
tb/testbench.sv
